// ===== src/bibir_pkg.sv =====
// Package for border island removal: sizes, register indexes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package bibir_pkg;
  localparam int MaxRows = 64;
  localparam int MaxCols = 64;
  localparam int RowW = 6;
  localparam int CntW = 7;
  localparam logic [0:0] RegRows = 1'b0;
  localparam logic [0:0] RegCols = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD, ST_SWEEP_RD, ST_SWEEP_WB, ST_OUT_RD, ST_OUT_EMIT
  } state_t;

  typedef struct packed {
    logic         we;
    logic [RowW-1:0] waddr;
    logic [MaxCols-1:0] wdata;
    logic [RowW-1:0] raddr;
  } mem_ctl_t;
endpackage

// ===== src/bibir_ram.sv =====
// Dual-port synchronous memory, one write and one registered read port.
// Depends on bibir_pkg.
`timescale 1ns / 1ps
module bibir_ram (
  input  logic clk,
  input  bibir_pkg::mem_ctl_t ctl,
  output logic [bibir_pkg::MaxCols-1:0] rdata
);
  logic [bibir_pkg::MaxCols-1:0] mem [bibir_pkg::MaxRows];
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    rdata <= mem[ctl.raddr];
  end
endmodule

// ===== src/binary_image_border_island_removal.sv =====
// Border island removal, 4-connected. Rows load while start is high; after the last row
// the reach set is grown by down/up sweep pairs, each row read (ST_SWEEP_RD) and written
// back (ST_SWEEP_WB) per sweep, until an up sweep changes nothing; then rows emit via
// ST_OUT_RD and ST_OUT_EMIT (no stall). Busy is held from the last row to the last beat.
// Reset returns control to loading and sets both registers to 64; memory contents are not reset.
// Depends on bibir_pkg, bibir_ram.
`timescale 1ns / 1ps
module binary_image_border_island_removal (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] row_pixels,
  output logic        strobe,
  output logic [63:0] cleaned_row,
  output logic [5:0]  out_row_index,
  output logic        last_row_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int RW = bibir_pkg::RowW;
  localparam int CW = bibir_pkg::CntW;

  bibir_pkg::state_t state, state_next;
  logic [CW-1:0] rows_in_use, columns_in_use, rows_loaded;
  logic [RW-1:0] row, row_next;
  logic dir, dir_next, changed, changed_next;
  logic [63:0] prev_reach, prev_reach_next;
  logic [63:0] img_q, reach_q;
  bibir_pkg::mem_ctl_t img_ctl, rch_ctl;
  logic [CW-1:0] nr, nc;
  logic [63:0] cm, edges, seed;
  logic [RW-1:0] last_r;
  logic wr_cfg;

  bibir_ram u_img (.clk(clk), .ctl(img_ctl), .rdata(img_q));
  bibir_ram u_rch (.clk(clk), .ctl(rch_ctl), .rdata(reach_q));

  assign pready = 1'b1;
  assign wr_cfg = psel && penable && pwrite && pready;
  always_comb begin
    case (paddr[2])
      bibir_pkg::RegRows: prdata = {25'd0, rows_in_use};
      bibir_pkg::RegCols: prdata = {25'd0, columns_in_use};
      default:            prdata = '0;
    endcase
  end

  assign nr = (rows_in_use == '0) ? CW'(1) : (rows_in_use > CW'(64) ? CW'(64) : rows_in_use);
  assign nc = (columns_in_use == '0) ? CW'(1) :
              (columns_in_use > CW'(64) ? CW'(64) : columns_in_use);
  assign cm = (nc[6]) ? '1 : ((64'd1 << nc[5:0]) - 64'd1);
  assign last_r = RW'(nr - CW'(1));
  assign edges = 64'd1 | (64'd1 << RW'(nc - CW'(1)));
  assign busy = (state != bibir_pkg::ST_LOAD);

  // Border seed for the current row.
  always_comb begin
    if (row == '0 || row == last_r) seed = img_q;
    else seed = img_q & edges;
  end

  // Right-going runs via carry; left-going via reversed carry.
  logic [63:0] spread;
  always_comb begin
    logic [63:0] s, ri, rs, rsum;
    s = (reach_q | seed | (prev_reach & img_q)) & img_q;
    if ((row == '0 && !dir) || (row == last_r && dir)) s = (reach_q | seed) & img_q;
    spread = ((img_q + s) ^ img_q) & img_q | s;
    for (int i = 0; i < 64; i++) begin
      ri[i] = img_q[63-i];
      rs[i] = spread[63-i];
    end
    rsum = ((ri + rs) ^ ri) & ri | rs;
    for (int i = 0; i < 64; i++) spread[i] = rsum[63-i] | spread[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bibir_pkg::ST_LOAD;
      rows_in_use <= CW'(64);
      columns_in_use <= CW'(64);
      rows_loaded <= '0;
      row <= '0;
      dir <= 1'b0;
      changed <= 1'b0;
    end else begin
      state <= state_next;
      row <= row_next;
      dir <= dir_next;
      changed <= changed_next;
      if (wr_cfg) begin
        if (paddr[2]) columns_in_use <= pwdata[CW-1:0];
        else rows_in_use <= pwdata[CW-1:0];
        rows_loaded <= '0;
      end else if (start && !busy) begin
        rows_loaded <= (rows_loaded + CW'(1) >= nr) ? '0 : rows_loaded + CW'(1);
      end
    end
  end
  always_ff @(posedge clk) prev_reach <= prev_reach_next;

  always_comb begin
    state_next = state;
    row_next = row;
    dir_next = dir;
    changed_next = changed;
    prev_reach_next = prev_reach;
    strobe = 1'b0;
    img_ctl = '{we: 1'b0, waddr: rows_loaded[RW-1:0], wdata: row_pixels & cm, raddr: row};
    rch_ctl = '{we: 1'b0, waddr: row, wdata: spread, raddr: row};
    case (state)
      bibir_pkg::ST_LOAD: begin
        if (start) begin
          img_ctl.we = 1'b1;
          rch_ctl.we = 1'b1;
          rch_ctl.waddr = rows_loaded[RW-1:0];
          rch_ctl.wdata = '0;
          if (rows_loaded + CW'(1) >= nr) begin
            state_next = bibir_pkg::ST_SWEEP_RD;
            row_next = '0;
            dir_next = 1'b0;
            changed_next = 1'b0;
            prev_reach_next = '0;
          end
        end
      end
      bibir_pkg::ST_SWEEP_RD: state_next = bibir_pkg::ST_SWEEP_WB;
      bibir_pkg::ST_SWEEP_WB: begin
        rch_ctl.we = 1'b1;
        prev_reach_next = spread;
        if (spread != reach_q) changed_next = 1'b1;
        state_next = bibir_pkg::ST_SWEEP_RD;
        if (!dir && row != last_r) row_next = row + RW'(1);
        else if (dir && row != '0) row_next = row - RW'(1);
        else begin
          prev_reach_next = '0;
          if (changed || spread != reach_q || !dir) begin
            dir_next = !dir;
            changed_next = 1'b0;
            if (dir && !(changed || spread != reach_q)) begin
              state_next = bibir_pkg::ST_OUT_RD;
              row_next = '0;
            end
          end else begin
            state_next = bibir_pkg::ST_OUT_RD;
            row_next = '0;
          end
        end
      end
      bibir_pkg::ST_OUT_RD: state_next = bibir_pkg::ST_OUT_EMIT;
      bibir_pkg::ST_OUT_EMIT: begin
        strobe = 1'b1;
        if (row == last_r) state_next = bibir_pkg::ST_LOAD;
        else begin
          row_next = row + RW'(1);
          state_next = bibir_pkg::ST_OUT_RD;
        end
      end
      default: state_next = bibir_pkg::ST_LOAD;
    endcase
  end

  assign cleaned_row = reach_q & cm;
  assign out_row_index = row;
  assign last_row_out = (row == last_r);

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("result without busy");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && last_row_out |=> !busy) else $error("last row did not end image");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start)) else $error("busy without start");
endmodule

// ===== tb/bibir_checker.sv =====
// Checker for border island removal: watches the row, result and register ports,
// predicts each cleaned image by a border flood fill and compares. Uses bibir_pkg.
`timescale 1ns / 1ps
module bibir_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] row_pixels,
  input  logic        strobe,
  input  logic [63:0] cleaned_row,
  input  logic [5:0]  out_row_index,
  input  logic        last_row_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          rows_pending
);
  typedef struct packed {
    logic [63:0]                pixels;
    logic [bibir_pkg::RowW-1:0] index;
    logic                       last;
  } clean_row_t;

  clean_row_t                 clean_rows_q[$];
  logic [bibir_pkg::CntW-1:0] rows_cfg, cols_cfg;
  logic [63:0]                image[bibir_pkg::MaxRows];
  logic [63:0]                reach[bibir_pkg::MaxRows];
  int                         rows_held;

  assign rows_pending = clean_rows_q.size();

  function automatic int clamp_count(logic [bibir_pkg::CntW-1:0] v);
    int n;
    n = v;
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    return n;
  endfunction

  task automatic predict_image(int nr, int nc, logic [63:0] cm);
    logic [63:0] edges, cur, nxt, grown;
    bit changed;
    clean_row_t e;
    edges = 64'd1;
    if (nc >= 2) edges |= 64'd1 << (nc - 1);
    for (int r = 0; r < nr; r++)
      reach[r] = (r == 0 || r == nr - 1) ? image[r] : (image[r] & edges);
    changed = 1;
    while (changed) begin
      changed = 0;
      for (int r = 0; r < nr; r++) begin
        cur = reach[r];
        nxt = cur;
        if (r > 0) nxt |= reach[r-1] & image[r];
        if (r + 1 < nr) nxt |= reach[r+1] & image[r];
        grown = (nxt | (nxt << 1) | (nxt >> 1)) & image[r];
        while (grown != nxt) begin
          nxt = grown;
          grown = (nxt | (nxt << 1) | (nxt >> 1)) & image[r];
        end
        if (nxt != cur) begin
          reach[r] = nxt;
          changed = 1;
        end
      end
    end
    for (int r = 0; r < nr; r++) begin
      e.pixels = reach[r] & cm;
      e.index = r[bibir_pkg::RowW-1:0];
      e.last = (r == nr - 1);
      clean_rows_q.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    int nr, nc;
    logic [63:0] cm;
    clean_row_t e;
    if (rst) begin
      rows_cfg <= 7'd64;
      cols_cfg <= 7'd64;
      rows_held = 0;
      fail_count = 0;
      clean_rows_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == bibir_pkg::RegRows) rows_cfg <= pwdata[bibir_pkg::CntW-1:0];
        else cols_cfg <= pwdata[bibir_pkg::CntW-1:0];
        rows_held = 0;
      end
      if (start && !busy) begin
        nr = clamp_count(rows_cfg);
        nc = clamp_count(cols_cfg);
        cm = (nc >= 64) ? '1 : ((64'd1 << nc) - 1);
        if (rows_held >= nr) rows_held = 0;
        image[rows_held] = row_pixels & cm;
        rows_held++;
        if (rows_held >= nr) begin
          rows_held = 0;
          predict_image(nr, nc, cm);
        end
      end
      if (strobe) begin
        if (clean_rows_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected row beat: idx %0d row %h", out_row_index, cleaned_row);
        end else begin
          e = clean_rows_q.pop_front();
          if (e.pixels !== cleaned_row || e.index !== out_row_index
              || e.last !== last_row_out) begin
            fail_count++;
            if (fail_count <= 10)
              $display("row mismatch: exp idx %0d last %0b %h, got idx %0d last %0b %h",
                       e.index, e.last, e.pixels, out_row_index, last_row_out,
                       cleaned_row);
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb_top.sv =====
// Top of the border island removal testbench: clock, reset, row and register stimulus,
// verdict. Depends on bibir_pkg, binary_image_border_island_removal, bibir_checker.
`timescale 1ns / 1ps
module tb_top;
  logic        clk = 0, rst = 1, start = 0, psel = 0, penable = 0, pwrite = 0;
  logic [63:0] row_pixels = '0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic        busy, strobe, last_row_out, pready;
  logic [63:0] cleaned_row;
  logic [5:0]  out_row_index;
  logic [31:0] prdata;
  int          fail_count, rows_pending, rows_sent;

  always #1 clk = ~clk;

  binary_image_border_island_removal i_dut (.*);
  bibir_checker i_checker (.*);

  task automatic load_row(logic [63:0] v);
    int pct;
    pct = rows_sent < 120 ? 33 : (rows_sent < 240 ? 64 : 0);
    if ($urandom_range(99) < pct) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1;
    row_pixels <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    rows_sent++;
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] v);
    start <= 0;
    @(posedge clk);
    wait (!busy && rows_pending == 0);
    repeat (30) @(posedge clk);
    psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] random_row();
    logic [63:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return a & b;
      1: return a | b;
      2: return '1;
      3: return '0;
      default: return a;
    endcase
  endfunction

  initial begin
    int rows_set[11] = '{3, 1, 2, 64, 7, 0, 127, 12, 4, 64, 33};
    int cols_set[11] = '{3, 1, 64, 64, 9, 0, 100, 17, 64, 1, 40};
    int nr, images;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // small directed images
    write_reg(bibir_pkg::RegRows, 3);
    write_reg(bibir_pkg::RegCols, 3);
    load_row('0); load_row('0); load_row('0);
    load_row('1); load_row('1); load_row('1);
    load_row(64'h0); load_row(64'h2); load_row(64'h0);
    load_row(64'h2); load_row(64'h2); load_row(64'h0);
    write_reg(bibir_pkg::RegRows, 5);
    write_reg(bibir_pkg::RegCols, 5);
    load_row(64'h1F); load_row(64'h11); load_row(64'h15);
    load_row(64'h11); load_row(64'h1F);
    load_row(64'h0); load_row(64'hE); load_row(64'hFFFF_FFFF_FFFF_FFEA);
    load_row(64'hE); load_row(64'h4);
    // partial image dropped by a register write
    load_row(64'h1F); load_row(64'h4);
    write_reg(bibir_pkg::RegRows, 5);
    for (int p = 0; rows_sent < 310; p = (p + 1) % 11) begin
      write_reg(bibir_pkg::RegRows, rows_set[p]);
      write_reg(bibir_pkg::RegCols, cols_set[p]);
      nr = rows_set[p] == 0 ? 1 : (rows_set[p] > 64 ? 64 : rows_set[p]);
      images = nr >= 20 ? 1 : 20 / nr;
      repeat (images * nr) load_row(random_row());
    end
    start <= 0;
    @(posedge clk);
    wait (!busy && rows_pending == 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end
endmodule

// ===== binary_image_border_island_removal.f =====
src/bibir_pkg.sv
src/bibir_ram.sv
src/binary_image_border_island_removal.sv
tb/bibir_checker.sv
tb/tb_top.sv
